FILE: hw/rtl/fdds_pkg.sv
// shared types, constants and elaboration-time helpers for the display scan
// no dependencies
`default_nettype none

package fdds_pkg;

	localparam int NUM_W          = 14;
	localparam int BCD_W          = 4;
	localparam int SEL_W          = 4;
	localparam int MAX_DIGITS     = 4;
	localparam int DIGIT_COUNT_DEF = 4;
	localparam int STEP_W         = 3;
	localparam int DIGITS_W       = BCD_W * MAX_DIGITS;

	// floor(x / 10) == (x * 52429) >> 19 for every x below 2**14
	localparam int RECIP_W        = 16;
	localparam int RECIP_SHIFT    = 19;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;

	typedef enum logic {
		PHASE_ENABLE  = 1'b0,
		PHASE_DISABLE = 1'b1
	} phase_t;

	typedef struct packed {
		logic [NUM_W-1:0]    value;
		logic [DIGITS_W-1:0] digits;
	} pipe_t;

	// digit count limited to the available select lines
	function automatic int eff_digits(input int n);
		int r;
		r = n;
		if (r < 1) r = 1;
		if (r > MAX_DIGITS) r = MAX_DIGITS;
		return r;
	endfunction

	function automatic int pow10(input int n);
		int r;
		r = 1;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (i < n) r = r * 10;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/four_digit_display_scan.sv
// four-digit multiplexed bcd display scan, top level
// a number passes the input register, one register per digit stage and the sequencer
// before its first scan step shows. the output sequencer gives one scan step per cycle
// while out_stall is low, two per digit; numbers enter every cycle until the digit
// pipeline is full. arst_n clears all valid bits and the sequencer at once
// depends on fdds_pkg, fdds_digit_stage, fdds_scan_seq
`default_nettype none

module four_digit_display_scan
	import fdds_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [NUM_W-1:0] number,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [SEL_W-1:0]      select_lines,
	output logic [BCD_W-1:0]      bcd_value,
	output logic                  phase,
	output logic                  last
);

	// digits actually scanned, bounded by the four select lines
	localparam int EFF = eff_digits(DIGIT_COUNT);
	// smallest number that no longer fits on the display
	localparam logic [NUM_W:0] LIMIT = (NUM_W+1)'(pow10(EFF));

	// stage 1: input register, out-of-range numbers are dropped here
	logic             valid_s1;
	logic [NUM_W-1:0] number_s1;
	logic             in_range;

	// handshake chain through the digit stages, index 0 is stage 1
	logic  valid_c [EFF+1];
	logic  ready_c [EFF+1];
	pipe_t pipe_c  [EFF+1];

	assign in_range = ({1'b0, number} < LIMIT);
	assign in_stall = !(!valid_s1 || ready_c[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			number_s1 <= number;
		end
	end

	assign valid_c[0]         = valid_s1;
	assign pipe_c[0].value    = number_s1;
	assign pipe_c[0].digits   = '0;

	// one stage per digit, units digit first
	for (genvar g = 0; g < EFF; g++) begin : g_digit
		fdds_digit_stage #(
			.DIGIT_POS(g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[g]),
			.in_ready (ready_c[g]),
			.in_pipe  (pipe_c[g]),
			.out_valid(valid_c[g+1]),
			.out_ready(ready_c[g+1]),
			.out_pipe (pipe_c[g+1])
		);
	end

	// sequencer holds one number's digits and walks its scan steps
	fdds_scan_seq #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_c[EFF]),
		.in_ready    (ready_c[EFF]),
		.in_digits   (pipe_c[EFF].digits),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.select_lines(select_lines),
		.bcd_value   (bcd_value),
		.phase       (phase),
		.last        (last)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/fdds_digit_stage.sv
// one pipeline stage that peels the next decimal digit off the value
// depends on fdds_pkg
`default_nettype none

module fdds_digit_stage
	import fdds_pkg::*;
#(
	parameter int DIGIT_POS = 0
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire pipe_t in_pipe,
	output logic       out_valid,
	input  wire logic  out_ready,
	output pipe_t      out_pipe
);

	logic [NUM_W+RECIP_W-1:0] prod;
	logic [NUM_W-1:0]         quo;
	logic [NUM_W-1:0]         rem;
	pipe_t                    next_pipe;
	logic                     valid_s2;
	pipe_t                    pipe_s2;

	// divide by ten through the reciprocal, remainder by shift and subtract
	always_comb begin
		prod      = {{RECIP_W{1'b0}}, in_pipe.value} * {{NUM_W{1'b0}}, RECIP_TEN};
		quo       = NUM_W'(prod >> RECIP_SHIFT);
		rem       = in_pipe.value - (quo << 3) - (quo << 1);
		next_pipe = in_pipe;
		next_pipe.value = quo;
		next_pipe.digits[DIGIT_POS*BCD_W +: BCD_W] = rem[BCD_W-1:0];
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pipe_s2 <= next_pipe;
		end
	end

	assign out_valid = valid_s2;
	assign out_pipe  = pipe_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/fdds_scan_seq.sv
// output sequencer: two scan steps per digit, units digit first
// depends on fdds_pkg
`default_nettype none

module fdds_scan_seq
	import fdds_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [DIGITS_W-1:0] in_digits,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [SEL_W-1:0]         select_lines,
	output logic [BCD_W-1:0]         bcd_value,
	output logic                     phase,
	output logic                     last
);

	localparam int EFF = eff_digits(DIGIT_COUNT);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * EFF - 1);

	logic [DIGITS_W-1:0] digits_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                xfer;
	logic [1:0]          idx;
	logic [SEL_W-1:0]    onehot;

	assign xfer     = busy_q && !out_stall;
	assign last     = (step_q == LAST_STEP);
	assign in_ready = !busy_q || (xfer && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_ready && in_valid) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (xfer) begin
			if (last) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			digits_q <= in_digits;
		end
	end

	always_comb begin
		idx    = step_q[STEP_W-1:1];
		onehot = SEL_W'(1) << idx;
		phase  = step_q[0];
		if (phase == PHASE_ENABLE) begin
			select_lines = ~onehot;
		end else begin
			select_lines = onehot;
		end
		bcd_value = digits_q[idx*BCD_W +: BCD_W];
	end

	assign out_valid = busy_q;

endmodule

`default_nettype wire
